@@ hw/rtl/rfd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the ramp filter detector row.
// Used by the channel interfaces, the work memory, the butterfly unit and the top level.
package rfd_pkg;

   localparam int MAX_COLS_DEF = 64;
   localparam int FFT_LEN_DEF = 128;
   localparam int SAMPLE_W = 24;
   localparam int COLS_W = 7;
   localparam int GAIN_W = 16;
   localparam int DW = 46;
   localparam int BIN_W = 36;
   localparam int TW_W = 17;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam int COLS_RESET = 64;
   localparam int GAIN_RESET = 256;

   localparam logic [CSR_IDX_W-1:0] REG_COLS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN = CSR_IDX_W'(1);

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic cap;
      logic inverse;
   } bfly_ctl_type;

   function automatic longint sat_to(input longint x, input int w);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (w - 1));
      if (x > hi) begin
         return hi;
      end
      if (x < lo) begin
         return lo;
      end
      return x;
   endfunction

   function automatic int lg_for(input int n);
      int e;
      e = 16;
      for (int k = 15; k >= 0; k--) begin
         if ((1 << k) >= n) begin
            e = k;
         end
      end
      return e + 1;
   endfunction

   function automatic longint to_q15(input longint v);
      return sat_to((v + 64'sd16384) >>> 15, TW_W);
   endfunction

   function automatic logic signed [TW_W-1:0] tw_val(input int m, input int lg_n,
                                                     input bit want_cos);
      longint unsigned q;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned ts;
      longint unsigned tc;
      longint ss;
      longint cc;
      longint res;
      q = 64'd1 << (lg_n - 2);
      r = (longint'(m) < q) ? longint'(m) : longint'(m) - q;
      x = (PI_Q30 * 64'd2 * r + (64'd1 << (lg_n - 1))) >> lg_n;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      cc = 64'sd1 <<< 30;
      ts = ((ts * x2) >> 30) / 64'd6;
      tc = ((tc * x2) >> 30) / 64'd2;
      ss = ss - longint'(ts);
      cc = cc - longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd20;
      tc = ((tc * x2) >> 30) / 64'd12;
      ss = ss + longint'(ts);
      cc = cc + longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd42;
      tc = ((tc * x2) >> 30) / 64'd30;
      ss = ss - longint'(ts);
      cc = cc - longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd72;
      tc = ((tc * x2) >> 30) / 64'd56;
      ss = ss + longint'(ts);
      cc = cc + longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd110;
      tc = ((tc * x2) >> 30) / 64'd90;
      ss = ss - longint'(ts);
      cc = cc - longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd156;
      tc = ((tc * x2) >> 30) / 64'd132;
      ss = ss + longint'(ts);
      cc = cc + longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd210;
      tc = ((tc * x2) >> 30) / 64'd182;
      ss = ss - longint'(ts);
      cc = cc - longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd272;
      tc = ((tc * x2) >> 30) / 64'd240;
      ss = ss + longint'(ts);
      cc = cc + longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd342;
      tc = ((tc * x2) >> 30) / 64'd306;
      ss = ss - longint'(ts);
      cc = cc - longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd420;
      tc = ((tc * x2) >> 30) / 64'd380;
      ss = ss + longint'(ts);
      cc = cc + longint'(tc);
      if (longint'(m) < q) begin
         res = want_cos ? to_q15(cc) : to_q15(ss);
      end else begin
         res = want_cos ? -to_q15(ss) : to_q15(cc);
      end
      return res[TW_W-1:0];
   endfunction

endpackage

@@ hw/rtl/rfd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample input, filtered output and register writes.
// Depends on rfd_pkg for the field widths.
interface rfd_req_if;
   logic valid;
   logic ready;
   logic signed [rfd_pkg::SAMPLE_W-1:0] sample;
   modport source(output valid, output sample, input ready);
   modport sink(input valid, input sample, output ready);
endinterface

interface rfd_rsp_if;
   logic valid;
   logic ready;
   logic signed [rfd_pkg::SAMPLE_W-1:0] filtered;
   logic last;
   modport source(output valid, output filtered, output last, input ready);
   modport sink(input valid, input filtered, input last, output ready);
endinterface

interface rfd_csr_if;
   logic valid;
   logic ready;
   logic [rfd_pkg::CSR_IDX_W-1:0] index;
   logic [rfd_pkg::CSR_DATA_W-1:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/rfd_mem.sv @@
`timescale 1ns / 1ps
// Work memory of complex words: one write port and two registered read ports.
// Depends on rfd_pkg for the default widths; the instantiating module sets the actual ones.
module rfd_mem #(
   parameter int DEPTH = rfd_pkg::FFT_LEN_DEF,
   parameter int AW = $clog2(rfd_pkg::FFT_LEN_DEF),
   parameter int EW = 2 * rfd_pkg::DW
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [EW-1:0] rd_data_a,
   output logic [EW-1:0] rd_data_b
);

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_a_ff;
   logic [EW-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hw/rtl/rfd_bfly.sv @@
`timescale 1ns / 1ps
// Radix-2 butterfly and ramp multiply unit with registered products.
// Depends on rfd_pkg for widths, saturation and the twiddle function.
module rfd_bfly #(
   parameter int FFT_LEN = rfd_pkg::FFT_LEN_DEF,
   parameter int LG = $clog2(rfd_pkg::FFT_LEN_DEF),
   parameter int HW = $clog2(rfd_pkg::FFT_LEN_DEF) + rfd_pkg::GAIN_W,
   parameter int LGW = $clog2($clog2(rfd_pkg::FFT_LEN_DEF) + 9)
) (
   input  logic                           clock,
   input  rfd_pkg::bfly_ctl_type          ctl,
   input  logic [LG-2:0]                  tw_idx,
   input  logic [HW-1:0]                  h,
   input  logic [LGW-1:0]                 shamt,
   input  logic [2*rfd_pkg::DW-1:0]       u_word,
   input  logic [2*rfd_pkg::DW-1:0]       a_word,
   output logic [2*rfd_pkg::DW-1:0]       nu_word,
   output logic [2*rfd_pkg::DW-1:0]       na_word,
   output logic [2*rfd_pkg::DW-1:0]       nr_word
);

   localparam int DW = rfd_pkg::DW;
   localparam int TW_W = rfd_pkg::TW_W;
   localparam int HALF = FFT_LEN / 2;

   logic signed [TW_W-1:0] cos_tab [HALF];
   logic signed [TW_W-1:0] sin_tab [HALF];

   for (genvar m = 0; m < HALF; m++) begin : g_tw
      localparam logic signed [TW_W-1:0] COS_V = rfd_pkg::tw_val(m, LG, 1'b1);
      localparam logic signed [TW_W-1:0] SIN_V = rfd_pkg::tw_val(m, LG, 1'b0);
      assign cos_tab[m] = COS_V;
      assign sin_tab[m] = SIN_V;
   end

   logic signed [TW_W-1:0] wr;
   logic signed [TW_W-1:0] wi;
   logic signed [DW-1:0] a_re;
   logic signed [DW-1:0] a_im;
   logic signed [rfd_pkg::BIN_W-1:0] b_re;
   logic signed [rfd_pkg::BIN_W-1:0] b_im;
   longint sat_re;
   longint sat_im;

   longint p0_ff, p1_ff, p2_ff, p3_ff, r0_ff, r1_ff;
   logic signed [DW-1:0] u_re_ff;
   logic signed [DW-1:0] u_im_ff;

   always_comb begin
      wr = cos_tab[tw_idx];
      wi = ctl.inverse ? sin_tab[tw_idx] : -sin_tab[tw_idx];
      a_re = a_word[2*DW-1:DW];
      a_im = a_word[DW-1:0];
      sat_re = rfd_pkg::sat_to(longint'(a_re), rfd_pkg::BIN_W);
      sat_im = rfd_pkg::sat_to(longint'(a_im), rfd_pkg::BIN_W);
      b_re = sat_re[rfd_pkg::BIN_W-1:0];
      b_im = sat_im[rfd_pkg::BIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.cap) begin
         p0_ff <= longint'(a_re) * longint'(wr);
         p1_ff <= longint'(a_im) * longint'(wi);
         p2_ff <= longint'(a_re) * longint'(wi);
         p3_ff <= longint'(a_im) * longint'(wr);
         r0_ff <= longint'(b_re) * longint'({1'b0, h});
         r1_ff <= longint'(b_im) * longint'({1'b0, h});
         u_re_ff <= u_word[2*DW-1:DW];
         u_im_ff <= u_word[DW-1:0];
      end
   end

   longint vr, vi, s_ur, s_ui, s_ar, s_ai, rnd, q_re, q_im;

   always_comb begin
      vr = (p0_ff - p1_ff + 64'sd16384) >>> 15;
      vi = (p2_ff + p3_ff + 64'sd16384) >>> 15;
      s_ur = rfd_pkg::sat_to(longint'(u_re_ff) + vr, DW);
      s_ui = rfd_pkg::sat_to(longint'(u_im_ff) + vi, DW);
      s_ar = rfd_pkg::sat_to(longint'(u_re_ff) - vr, DW);
      s_ai = rfd_pkg::sat_to(longint'(u_im_ff) - vi, DW);
      rnd = 64'sd1 <<< (shamt - LGW'(1));
      q_re = rfd_pkg::sat_to((r0_ff + rnd) >>> shamt, DW);
      q_im = rfd_pkg::sat_to((r1_ff + rnd) >>> shamt, DW);
      nu_word = {s_ur[DW-1:0], s_ui[DW-1:0]};
      na_word = {s_ar[DW-1:0], s_ai[DW-1:0]};
      nr_word = {q_re[DW-1:0], q_im[DW-1:0]};
   end

endmodule

@@ hw/rtl/ramp_filter_detector_row.sv @@
`timescale 1ns / 1ps
// Ramp filter for one detector row: a sequencer around the work memory and butterfly unit.
// Depends on rfd_pkg, rfd_if, rfd_mem and rfd_bfly.
//
// Samples are taken one per cycle until cols_in_use of them are held; the row is then
// padded to P = 2 * next_pow2(cols) points, bit-reversed, transformed, ramp-weighted,
// bit-reversed and inverse-transformed in the work memory, and the first cols_in_use real
// parts leave as transactions on the response channel, the final one with last set. Each
// butterfly runs through read, multiply, write and write steps in turn, as the work memory
// has a single write port. No new sample is taken until the last result of the row has
// been delivered.
module ramp_filter_detector_row #(
   parameter int MAX_COLS = rfd_pkg::MAX_COLS_DEF,
   parameter int FFT_LEN = rfd_pkg::FFT_LEN_DEF
) (
   input logic clock,
   input logic reset,
   rfd_req_if.sink req_ch,
   rfd_rsp_if.source rsp_ch,
   rfd_csr_if.sink csr_ch
);

   localparam int LG = $clog2(FFT_LEN);
   localparam int LGW = $clog2(LG + 9);
   localparam int HW = LG + rfd_pkg::GAIN_W;
   localparam int DW = rfd_pkg::DW;
   localparam int EW = 2 * DW;
   localparam int SW = rfd_pkg::SAMPLE_W;

   typedef enum logic [14:0] {
      S_LOAD     = 15'b000000000000001,
      S_PAD      = 15'b000000000000010,
      S_BR_RD    = 15'b000000000000100,
      S_BR_WI    = 15'b000000000001000,
      S_BR_WJ    = 15'b000000000010000,
      S_BF_RD    = 15'b000000000100000,
      S_BF_MUL   = 15'b000000001000000,
      S_BF_WU    = 15'b000000010000000,
      S_BF_WA    = 15'b000000100000000,
      S_RM_RD    = 15'b000001000000000,
      S_RM_MUL   = 15'b000010000000000,
      S_RM_WR    = 15'b000100000000000,
      S_OUT_RD   = 15'b001000000000000,
      S_OUT_CAP  = 15'b010000000000000,
      S_OUT_HOLD = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [rfd_pkg::COLS_W-1:0] cols_ff, cols_in;
   logic [rfd_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [LG-1:0] load_cnt_ff, load_cnt_in;
   logic [LG-1:0] n_ff, n_in;
   logic [LGW-1:0] lg_ff, lg_in;
   logic [LG-1:0] p_m1_ff, p_m1_in;
   logic [LG-1:0] idx_ff, idx_in;
   logic [LG-1:0] jr_ff, jr_in;
   logic [LGW-1:0] stage_ff, stage_in;
   logic [LG-1:0] j_ff, j_in;
   logic [LG-1:0] base_ff, base_in;
   logic inv_ff, inv_in;
   logic [HW-1:0] h_ff, h_in;
   logic signed [SW-1:0] out_data_ff, out_data_in;
   logic out_last_ff, out_last_in;

   logic mem_we, mem_re;
   logic [LG-1:0] mem_waddr, mem_ra, mem_rb;
   logic [EW-1:0] mem_wdata, rd_a, rd_b;
   logic [EW-1:0] nu_word, na_word, nr_word;
   rfd_pkg::bfly_ctl_type bctl;

   logic [31:0] n32;
   logic [LG-1:0] n_eff;
   int lg_new;
   logic [LG-1:0] rev;
   logic [LG-1:0] partner;
   logic [LG-1:0] half;
   logic [LG-1:0] u_addr;
   logic [LG-1:0] a_addr;
   logic [LG:0] base_next;
   logic [LG-1:0] tw_full;
   logic [LG:0] p_len;
   logic [LG:0] ak;
   logic [LGW-1:0] shamt;
   longint o_re;
   longint o_val;
   logic br_done;

   rfd_mem #(.DEPTH(FFT_LEN), .AW(LG), .EW(EW)) u_mem (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (mem_waddr),
      .wr_data  (mem_wdata),
      .rd_en    (mem_re),
      .rd_addr_a(mem_ra),
      .rd_addr_b(mem_rb),
      .rd_data_a(rd_a),
      .rd_data_b(rd_b)
   );

   rfd_bfly #(.FFT_LEN(FFT_LEN), .LG(LG), .HW(HW), .LGW(LGW)) u_bfly (
      .clock  (clock),
      .ctl    (bctl),
      .tw_idx (tw_full[LG-2:0]),
      .h      (h_ff),
      .shamt  (shamt),
      .u_word (rd_a),
      .a_word (rd_b),
      .nu_word(nu_word),
      .na_word(na_word),
      .nr_word(nr_word)
   );

   assign req_ch.ready = (state_ff == S_LOAD);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = (state_ff == S_OUT_HOLD);
   assign rsp_ch.filtered = out_data_ff;
   assign rsp_ch.last = out_last_ff;

   always_comb begin
      n32 = 32'(cols_ff);
      if (n32 < 32'd1) begin
         n32 = 32'd1;
      end
      if (n32 > 32'(MAX_COLS)) begin
         n32 = 32'(MAX_COLS);
      end
      if (n32 > 32'(FFT_LEN / 2)) begin
         n32 = 32'(FFT_LEN / 2);
      end
      n_eff = n32[LG-1:0];
      lg_new = rfd_pkg::lg_for(int'(n32));
      for (int k = 0; k < LG; k++) begin
         rev[k] = idx_ff[LG-1-k];
      end
      partner = rev >> (LG - int'(lg_ff));
      br_done = (idx_ff == p_m1_ff);
      half = LG'(1) << (stage_ff - LGW'(1));
      u_addr = base_ff + j_ff;
      a_addr = u_addr + half;
      base_next = {1'b0, base_ff} + {half, 1'b0};
      tw_full = j_ff << (LG - int'(stage_ff));
      p_len = {1'b0, p_m1_ff} + (LG+1)'(1);
      ak = ({1'b0, idx_ff} <= (p_len >> 1)) ? {1'b0, idx_ff} : p_len - {1'b0, idx_ff};
      shamt = lg_ff + LGW'(8);
      o_re = longint'($signed(rd_b[EW-1:DW]));
      o_val = rfd_pkg::sat_to((o_re + (64'sd1 <<< (lg_ff - LGW'(1)))) >>> lg_ff, SW);
   end

   always_comb begin
      state_in = state_ff;
      cols_in = cols_ff;
      gain_in = gain_ff;
      load_cnt_in = load_cnt_ff;
      n_in = n_ff;
      lg_in = lg_ff;
      p_m1_in = p_m1_ff;
      idx_in = idx_ff;
      jr_in = jr_ff;
      stage_in = stage_ff;
      j_in = j_ff;
      base_in = base_ff;
      inv_in = inv_ff;
      h_in = h_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '0;
      mem_ra = idx_ff;
      mem_rb = idx_ff;
      bctl.cap = 1'b0;
      bctl.inverse = inv_ff;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            rfd_pkg::REG_COLS: cols_in = csr_ch.data[rfd_pkg::COLS_W-1:0];
            rfd_pkg::REG_GAIN: gain_in = csr_ch.data[rfd_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_LOAD: begin
            if (req_ch.valid) begin
               mem_we = 1'b1;
               mem_waddr = load_cnt_ff;
               mem_wdata = {DW'(req_ch.sample), DW'(0)};
               if (({1'b0, load_cnt_ff} + (LG+1)'(1)) >= {1'b0, n_eff}) begin
                  load_cnt_in = '0;
                  n_in = n_eff;
                  lg_in = LGW'(lg_new);
                  p_m1_in = LG'((1 << lg_new) - 1);
                  idx_in = n_eff;
                  state_in = S_PAD;
               end else begin
                  load_cnt_in = load_cnt_ff + LG'(1);
               end
            end
         end
         S_PAD: begin
            mem_we = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = '0;
            if (br_done) begin
               idx_in = LG'(1);
               inv_in = 1'b0;
               state_in = S_BR_RD;
            end else begin
               idx_in = idx_ff + LG'(1);
            end
         end
         S_BR_RD, S_BR_WJ: begin
            if (state_ff == S_BR_WJ) begin
               mem_we = 1'b1;
               mem_waddr = jr_ff;
               mem_wdata = rd_a;
            end
            if ((state_ff == S_BR_RD) && (idx_ff < partner)) begin
               mem_re = 1'b1;
               mem_ra = idx_ff;
               mem_rb = partner;
               jr_in = partner;
               state_in = S_BR_WI;
            end else if (br_done) begin
               stage_in = LGW'(1);
               base_in = '0;
               j_in = '0;
               state_in = S_BF_RD;
            end else begin
               idx_in = idx_ff + LG'(1);
               state_in = S_BR_RD;
            end
         end
         S_BR_WI: begin
            mem_we = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = rd_b;
            state_in = S_BR_WJ;
         end
         S_BF_RD: begin
            mem_re = 1'b1;
            mem_ra = u_addr;
            mem_rb = a_addr;
            state_in = S_BF_MUL;
         end
         S_BF_MUL: begin
            bctl.cap = 1'b1;
            state_in = S_BF_WU;
         end
         S_BF_WU: begin
            mem_we = 1'b1;
            mem_waddr = u_addr;
            mem_wdata = nu_word;
            state_in = S_BF_WA;
         end
         S_BF_WA: begin
            mem_we = 1'b1;
            mem_waddr = a_addr;
            mem_wdata = na_word;
            state_in = S_BF_RD;
            if ((j_ff + LG'(1)) == half) begin
               j_in = '0;
               if (base_next > {1'b0, p_m1_ff}) begin
                  base_in = '0;
                  if (stage_ff == lg_ff) begin
                     idx_in = '0;
                     state_in = inv_ff ? S_OUT_RD : S_RM_RD;
                  end else begin
                     stage_in = stage_ff + LGW'(1);
                  end
               end else begin
                  base_in = base_next[LG-1:0];
               end
            end else begin
               j_in = j_ff + LG'(1);
            end
         end
         S_RM_RD: begin
            mem_re = 1'b1;
            mem_rb = idx_ff;
            h_in = HW'(ak[LG-1:0]) * HW'(gain_ff);
            if ({ak, 1'b0} > {1'b0, p_len}) begin
               h_in = '0;
            end
            state_in = S_RM_MUL;
         end
         S_RM_MUL: begin
            bctl.cap = 1'b1;
            state_in = S_RM_WR;
         end
         S_RM_WR: begin
            mem_we = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = nr_word;
            if (br_done) begin
               idx_in = LG'(1);
               inv_in = 1'b1;
               state_in = S_BR_RD;
            end else begin
               idx_in = idx_ff + LG'(1);
               state_in = S_RM_RD;
            end
         end
         S_OUT_RD: begin
            mem_re = 1'b1;
            mem_rb = idx_ff;
            state_in = S_OUT_CAP;
         end
         S_OUT_CAP: begin
            out_data_in = o_val[SW-1:0];
            out_last_in = (idx_ff == (n_ff - LG'(1)));
            state_in = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp_ch.ready) begin
               if (out_last_ff) begin
                  state_in = S_LOAD;
               end else begin
                  idx_in = idx_ff + LG'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cols_ff <= rfd_pkg::COLS_W'(rfd_pkg::COLS_RESET);
         gain_ff <= rfd_pkg::GAIN_W'(rfd_pkg::GAIN_RESET);
         load_cnt_ff <= '0;
         inv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cols_ff <= cols_in;
         gain_ff <= gain_in;
         load_cnt_ff <= load_cnt_in;
         inv_ff <= inv_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      lg_ff <= lg_in;
      p_m1_ff <= p_m1_in;
      idx_ff <= idx_in;
      jr_ff <= jr_in;
      stage_ff <= stage_in;
      j_ff <= j_in;
      base_ff <= base_in;
      h_ff <= h_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("sample taken while a result is pending");

   a_last_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last) |=> (state_ff == S_LOAD))
      else $error("row end did not return to loading");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BF_RD) |-> ((stage_ff != '0) && (stage_ff <= lg_ff)))
      else $error("butterfly stage out of range");

   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BR_WI) |-> (idx_ff < jr_ff))
      else $error("bit-reversal swap on a wrong pair");
`endif

endmodule

@@ tb/rfd_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the ramp filter detector row: watches the sample, register and result
// channels, predicts each row with a fixed-point FFT ramp filter and compares results.
// Depends on rfd_pkg and the channel interfaces in rfd_if.
module rfd_checker (
   input logic clock,
   input logic reset,
   rfd_req_if req_ch,
   rfd_rsp_if rsp_ch,
   rfd_csr_if csr_ch,
   output int fail_count,
   output int pending
);

   localparam int NPT = 128;
   localparam int HALFN = 64;
   localparam longint L46 = 64'sd1 <<< 45;
   localparam longint L36 = 64'sd1 <<< 35;
   localparam longint L24 = 64'sd1 <<< 23;

   typedef struct {
      logic signed [rfd_pkg::SAMPLE_W-1:0] filtered;
      logic last;
   } row_result_type;

   longint buf_re[NPT];
   longint buf_im[NPT];
   longint wcos[HALFN];
   longint wsin[HALFN];
   int held;
   logic [rfd_pkg::COLS_W-1:0] cols_reg;
   logic [rfd_pkg::GAIN_W-1:0] gain_reg;
   row_result_type expected_q[$];

   function automatic longint rshift(longint x, int s);
      longint y;
      y = x + (64'sd1 <<< (s - 1));
      return y >>> s;
   endfunction

   function automatic longint clip(longint x, longint lim);
      if (x > lim - 1) return lim - 1;
      if (x < -lim) return -lim;
      return x;
   endfunction

   function automatic longint q15(longint v);
      return clip(rshift(v, 15), 64'sd1 <<< 16);
   endfunction

   task automatic make_twiddles();
      longint unsigned r, x, x2, ts, tc;
      longint ss, cc;
      for (int m = 0; m < HALFN; m++) begin
         r = (m < NPT / 4) ? m : m - NPT / 4;
         x = (64'd3373259426 * 64'd2 * r + NPT / 2) / NPT;
         x2 = (x * x + (64'd1 << 29)) >> 30;
         ts = x;
         tc = 64'd1 << 30;
         ss = longint'(x);
         cc = 64'sd1 <<< 30;
         for (int i = 1; i <= 10; i++) begin
            ts = ((ts * x2) >> 30) / (longint'(2 * i) * longint'(2 * i + 1));
            tc = ((tc * x2) >> 30) / (longint'(2 * i - 1) * longint'(2 * i));
            if (i % 2 == 1) begin
               ss -= longint'(ts);
               cc -= longint'(tc);
            end else begin
               ss += longint'(ts);
               cc += longint'(tc);
            end
         end
         if (m < NPT / 4) begin
            wcos[m] = q15(cc);
            wsin[m] = q15(ss);
         end else begin
            wcos[m] = -q15(ss);
            wsin[m] = q15(cc);
         end
      end
   endtask

   task automatic run_fft(bit inv, int plen);
      int j, b, half, stp, idx;
      longint t, wr, wi, vr, vi, ur, ui;
      j = 0;
      for (int i = 1; i < plen; i++) begin
         b = plen >> 1;
         while (b != 0 && (j & b) != 0) begin
            j ^= b;
            b >>= 1;
         end
         j ^= b;
         if (i < j) begin
            t = buf_re[i]; buf_re[i] = buf_re[j]; buf_re[j] = t;
            t = buf_im[i]; buf_im[i] = buf_im[j]; buf_im[j] = t;
         end
      end
      for (int len = 2; len <= plen; len <<= 1) begin
         half = len >> 1;
         stp = NPT / len;
         for (int base = 0; base < plen; base += len) begin
            for (int k = 0; k < half; k++) begin
               idx = (k * stp) % HALFN;
               wr = wcos[idx];
               wi = inv ? wsin[idx] : -wsin[idx];
               vr = rshift(buf_re[base+k+half] * wr - buf_im[base+k+half] * wi, 15);
               vi = rshift(buf_re[base+k+half] * wi + buf_im[base+k+half] * wr, 15);
               ur = buf_re[base+k];
               ui = buf_im[base+k];
               buf_re[base+k] = clip(ur + vr, L46);
               buf_im[base+k] = clip(ui + vi, L46);
               buf_re[base+k+half] = clip(ur - vr, L46);
               buf_im[base+k+half] = clip(ui - vi, L46);
            end
         end
      end
   endtask

   task automatic filter_row(int n);
      int pw, plen, lg, ak;
      longint h;
      row_result_type res;
      pw = 1;
      while (pw < n) pw <<= 1;
      plen = 2 * pw;
      lg = $clog2(plen);
      for (int i = n; i < plen; i++) begin
         buf_re[i] = 0;
         buf_im[i] = 0;
      end
      run_fft(1'b0, plen);
      for (int i = 0; i < plen; i++) begin
         ak = (i <= plen / 2) ? i : plen - i;
         h = longint'(ak) * longint'(gain_reg);
         buf_re[i] = clip(rshift(clip(buf_re[i], L36) * h, lg + 8), L46);
         buf_im[i] = clip(rshift(clip(buf_im[i], L36) * h, lg + 8), L46);
      end
      run_fft(1'b1, plen);
      for (int i = 0; i < n; i++) begin
         res.filtered = rfd_pkg::SAMPLE_W'(clip(rshift(buf_re[i], lg), L24));
         res.last = (i == n - 1);
         expected_q.push_back(res);
      end
   endtask

   task automatic take_sample(logic signed [rfd_pkg::SAMPLE_W-1:0] s);
      int n;
      n = cols_reg;
      if (n < 1) n = 1;
      if (n > HALFN) n = HALFN;
      buf_re[held] = longint'(s);
      buf_im[held] = 0;
      held++;
      if (held >= n) begin
         held = 0;
         filter_row(n);
      end
   endtask

   initial make_twiddles();

   assign pending = expected_q.size() + held;

   always @(posedge clock) begin
      row_result_type e;
      if (reset) begin
         held = 0;
         cols_reg = rfd_pkg::COLS_W'(rfd_pkg::COLS_RESET);
         gain_reg = rfd_pkg::GAIN_W'(rfd_pkg::GAIN_RESET);
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result transaction filtered=%0d last=%0b", $time,
                        rsp_ch.filtered, rsp_ch.last);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (e.filtered !== rsp_ch.filtered || e.last !== rsp_ch.last) begin
                  $display("%0t: expected filtered=%0d last=%0b, actual filtered=%0d last=%0b",
                           $time, e.filtered, e.last, rsp_ch.filtered, rsp_ch.last);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) take_sample(req_ch.sample);
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == rfd_pkg::REG_COLS) cols_reg = csr_ch.data[rfd_pkg::COLS_W-1:0];
            else if (csr_ch.index == rfd_pkg::REG_GAIN) gain_reg = csr_ch.data;
         end
      end
   end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the ramp filter detector row: drives samples and register writes,
// varies idling on both channels and reports the verdict. Depends on rfd_pkg, rfd_if,
// rfd_checker and the block under test.
module tb_top;

   localparam int WATCH_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int send_idle = 0;
   int recv_stall = 0;
   int fail_count;
   int pending;
   int quiet;

   rfd_req_if req_ch();
   rfd_rsp_if rsp_ch();
   rfd_csr_if csr_ch();

   ramp_filter_detector_row u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   rfd_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = rfd_pkg::REG_COLS;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= WATCH_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [rfd_pkg::CSR_IDX_W-1:0] idx,
                            logic [rfd_pkg::CSR_DATA_W-1:0] val);
      bit taken;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do begin
         @(negedge clock);
         taken = csr_ch.ready;
         @(posedge clock);
      end while (!taken);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(logic signed [rfd_pkg::SAMPLE_W-1:0] s);
      bit taken;
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample <= s;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [rfd_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(5))
         0: return {1'b0, {(rfd_pkg::SAMPLE_W-1){1'b1}}};
         1: return {1'b1, {(rfd_pkg::SAMPLE_W-1){1'b0}}};
         2: return rfd_pkg::SAMPLE_W'($signed($urandom_range(8191)) - 4096);
         default: return rfd_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_rows(int count);
      for (int i = 0; i < count; i++) send_sample(pick_sample());
   endtask

   initial begin
      int cols;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_reg(rfd_pkg::REG_COLS, 16'd4);
      write_reg(rfd_pkg::REG_GAIN, 16'd256);
      send_sample({1'b0, {(rfd_pkg::SAMPLE_W-1){1'b1}}});
      send_sample({1'b1, {(rfd_pkg::SAMPLE_W-1){1'b0}}});
      send_sample('0);
      send_sample(-24'sd1);
      drain();
      write_reg(rfd_pkg::REG_GAIN, 16'hFFFF);
      for (int i = 0; i < 4; i++) send_sample({1'b0, {(rfd_pkg::SAMPLE_W-1){1'b1}}});
      drain();
      write_reg(rfd_pkg::REG_COLS, 16'd0);
      send_sample(24'sd4096);
      send_sample({1'b1, {(rfd_pkg::SAMPLE_W-1){1'b0}}});
      drain();
      write_reg(rfd_pkg::REG_GAIN, 16'd0);
      write_reg(rfd_pkg::REG_COLS, 16'd1);
      send_sample(24'sd12345);
      drain();
      write_reg(rfd_pkg::REG_COLS, 16'h7F);
      write_reg(rfd_pkg::REG_GAIN, 16'd256);
      send_rows(64);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle = (phase == 1 || phase == 3) ? ((phase == 1) ? 86 : 31) : 0;
         recv_stall = (phase == 2 || phase == 3) ? ((phase == 2) ? 86 : 31) : 0;
         for (int r = 0; r < 4; r++) begin
            cols = (r == 0) ? 64 : ($urandom_range(3) == 0 ? $urandom_range(64, 33)
                                                            : $urandom_range(16, 1));
            write_reg(rfd_pkg::REG_COLS, 16'(cols));
            write_reg(rfd_pkg::REG_GAIN, (r == 1) ? 16'hFFFF : 16'($urandom));
            send_rows(cols);
            drain();
         end
      end
      send_idle = 0;
      recv_stall = 0;
      drain();
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
